### rtl/rslt_pkg.sv
// Shared types and constants for the run segment line tracker.
package rslt_pkg;

  localparam int POS_W   = 13;
  localparam int LEN_W   = 14;
  localparam int THICK_W = 12;
  localparam int CFG_W   = 3;
  localparam int DATA_W  = 12;

  localparam logic [THICK_W-1:0] THICK_TOP = '1;

  localparam logic [CFG_W-1:0] CFG_DARK_LEVEL      = 3'd0;
  localparam logic [CFG_W-1:0] CFG_MIN_RUN         = 3'd1;
  localparam logic [CFG_W-1:0] CFG_LONG_RUN        = 3'd2;
  localparam logic [CFG_W-1:0] CFG_SHORT_THICK_MIN = 3'd3;
  localparam logic [CFG_W-1:0] CFG_LONG_THICK_MIN  = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0]   head;
    logic [POS_W-1:0]   tail;
    logic [LEN_W-1:0]   len;
    logic [THICK_W-1:0] thick;
  } seg_t;

  typedef struct packed {
    logic accept;
    logic line_done;
  } run_ctl_t;

  typedef enum logic [2:0] {
    ST_SCAN,
    ST_PREV_RD,
    ST_CUR_RD,
    ST_CMP,
    ST_DECIDE,
    ST_NEXT,
    ST_FLUSH,
    ST_SWAP
  } fsm_t;

endpackage

### rtl/rslt_seg_ram.sv
// Segment list memory with one write port and one registered read port.
module rslt_seg_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  rslt_pkg::seg_t      wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output rslt_pkg::seg_t      rdata
);

  rslt_pkg::seg_t mem [DEPTH];
  rslt_pkg::seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/rslt_run_det.sv
// Run detector: tracks position along the line and forms segments from dark runs.
module rslt_run_det #(
  parameter int LINE_MAX = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rslt_pkg::run_ctl_t  ctl,
  input  logic [7:0]          pixel,
  input  logic [7:0]          dark_level,
  input  logic [11:0]         min_run,
  input  logic                full,
  output logic                seg_we,
  output rslt_pkg::seg_t      seg
);

  localparam int PCW = $clog2(LINE_MAX + 1);

  logic [PCW-1:0] position_r, position_nxt;
  logic [PCW-1:0] run_head_r, run_head_nxt;
  logic           run_open_r, run_open_nxt;
  logic           pos_ok, opening, closing;
  logic [PCW-1:0] len;

  always_comb begin
    pos_ok  = position_r < PCW'(LINE_MAX);
    opening = pos_ok && (pixel < dark_level) && !run_open_r;
    closing = pos_ok && (pixel > dark_level) && run_open_r;
    len     = position_r - run_head_r;

    seg_we    = ctl.accept && closing && (32'(len) >= 32'(min_run)) && !full;
    seg.head  = rslt_pkg::POS_W'(run_head_r);
    seg.tail  = rslt_pkg::POS_W'(position_r - PCW'(1));
    seg.len   = rslt_pkg::LEN_W'(len);
    seg.thick = rslt_pkg::THICK_W'(1);

    position_nxt = position_r;
    run_head_nxt = run_head_r;
    run_open_nxt = run_open_r;
    if (ctl.accept) begin
      if (opening) begin
        run_open_nxt = 1'b1;
        run_head_nxt = position_r;
      end
      if (closing) begin
        run_open_nxt = 1'b0;
      end
      if (pos_ok) begin
        position_nxt = position_r + PCW'(1);
      end
      if (ctl.line_done) begin
        position_nxt = '0;
        run_open_nxt = 1'b0;
        run_head_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      run_head_r <= '0;
      run_open_r <= 1'b0;
    end else begin
      position_r <= position_nxt;
      run_head_r <= run_head_nxt;
      run_open_r <= run_open_nxt;
    end
  end

endmodule

### rtl/run_segment_line_tracker.sv
// Top level of the run segment line tracker: configuration, list matching and output.
//
// Pixels enter on the in_ channel, one word per cycle while a line is scanned.
// Dark runs of at least min_run pixels are stored as segments of the current
// line in one of two segment memories; the two memories swap roles at each
// line end, so the current list becomes the previous list without a copy.
// A word marked line_end or frame_end starts the end-of-line pass, during
// which in_ready is low. Each previous segment is read and then stepped past;
// each current segment tried from the match counter onward is read and
// compared, and a previous segment that finds no match also passes through the
// failed range check and the decision. Flush and list swap close the pass.
// Unmatched thick previous segments leave on the out_ channel, one word each,
// with out_last on the final word of that line end; a line end with no such
// segments gives no word. If the receiver stalls, the pass waits on the held
// word and the stall cycles add to the pass. Reset (rst_n low, synchronous)
// empties both lists, clears the line counter and loads the configuration
// defaults; memory contents stay as they are and are only read below the
// list counts.
module run_segment_line_tracker #(
  parameter int LINE_MAX  = 2048,
  parameter int SEG_MAX   = 64,
  parameter int LINES_MAX = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rslt_pkg::CFG_W-1:0]  cfg_index,
  input  logic [rslt_pkg::DATA_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_pixel,
  input  logic                        in_line_end,
  input  logic                        in_frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [11:0]                 out_line_index,
  output logic [10:0]                 out_run_start,
  output logic [10:0]                 out_run_stop,
  output logic [11:0]                 out_run_length,
  output logic [11:0]                 out_thickness,
  output logic                        out_last
);

  localparam int AW  = $clog2(SEG_MAX);
  localparam int CW  = $clog2(SEG_MAX + 1);
  localparam int LNW = $clog2(LINES_MAX);

  logic [7:0]  dark_r;
  logic [11:0] min_run_r, long_run_r, short_thick_r, long_thick_r;

  rslt_pkg::fsm_t state_r, state_nxt;
  logic [CW-1:0]  cur_count_r, cur_count_nxt;
  logic [CW-1:0]  prev_count_r, prev_count_nxt;
  logic [CW-1:0]  i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt;
  logic           bank_r, bank_nxt;
  logic           fe_r, fe_nxt;
  logic [LNW-1:0] line_r, line_nxt, prev_line;
  logic           pend_v_r, pend_v_nxt;
  rslt_pkg::seg_t pend_r, pend_nxt;

  logic           out_valid_r;
  rslt_pkg::seg_t out_seg_r;
  logic [11:0]    out_line_r;
  logic           out_last_r;
  logic           out_ld, out_ld_last, out_free;

  logic               in_acc;
  rslt_pkg::run_ctl_t run_ctl;
  logic               seg_we, full;
  rslt_pkg::seg_t     new_seg;

  logic           cur_we, cur_re, prev_re;
  logic [AW-1:0]  cur_waddr;
  rslt_pkg::seg_t cur_wdata, merged;
  rslt_pkg::seg_t rd0, rd1, p, c;
  logic           match, emit_ok;
  logic [16:0]    lp, lc;
  logic [rslt_pkg::THICK_W:0] tsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r        <= 8'd128;
      min_run_r     <= 12'd20;
      long_run_r    <= 12'd50;
      short_thick_r <= 12'd4;
      long_thick_r  <= 12'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rslt_pkg::CFG_DARK_LEVEL:      dark_r        <= cfg_data[7:0];
        rslt_pkg::CFG_MIN_RUN:         min_run_r     <= cfg_data;
        rslt_pkg::CFG_LONG_RUN:        long_run_r    <= cfg_data;
        rslt_pkg::CFG_SHORT_THICK_MIN: short_thick_r <= cfg_data;
        rslt_pkg::CFG_LONG_THICK_MIN:  long_thick_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready          = (state_r == rslt_pkg::ST_SCAN);
  assign in_acc            = in_valid && in_ready;
  assign run_ctl.accept    = in_acc;
  assign run_ctl.line_done = in_line_end || in_frame_end;
  assign full              = (cur_count_r == CW'(SEG_MAX));

  rslt_run_det #(
    .LINE_MAX (LINE_MAX)
  ) u_run_det (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (run_ctl),
    .pixel      (in_pixel),
    .dark_level (dark_r),
    .min_run    (min_run_r),
    .full       (full),
    .seg_we     (seg_we),
    .seg        (new_seg)
  );

  always_comb begin
    lp   = 17'(p.len);
    lc   = 17'(c.len);
    match = ((p.tail > c.head) && ((lc * 17'd4) < (lp * 17'd5)) &&
             ((lp * 17'd5) < (lc * 17'd6))) ||
            (((p.head == c.head) || (p.tail == c.tail)) && ((lp * 17'd2) > lc));
    tsum = {1'b0, c.thick} + {1'b0, p.thick};
    merged = c;
    merged.thick = tsum[rslt_pkg::THICK_W] ? rslt_pkg::THICK_TOP
                                           : tsum[rslt_pkg::THICK_W-1:0];
    if (p.len > c.len) begin
      merged.head = p.head;
      merged.tail = p.tail;
      merged.len  = p.len;
    end
    emit_ok = (32'(p.len) < 32'(long_run_r)) ? (p.thick >= short_thick_r)
                                             : (p.thick >= long_thick_r);
  end

  always_comb begin
    cur_re    = (state_r == rslt_pkg::ST_CUR_RD) && (j_r < cur_count_r);
    prev_re   = (state_r == rslt_pkg::ST_PREV_RD);
    cur_we    = seg_we || ((state_r == rslt_pkg::ST_CMP) && match);
    cur_waddr = (state_r == rslt_pkg::ST_SCAN) ? cur_count_r[AW-1:0] : j_r[AW-1:0];
    cur_wdata = (state_r == rslt_pkg::ST_SCAN) ? new_seg : merged;
  end

  rslt_seg_ram #(
    .DEPTH (SEG_MAX),
    .AW    (AW)
  ) u_ram0 (
    .clk   (clk),
    .we    (!bank_r && cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (bank_r ? prev_re : cur_re),
    .raddr (bank_r ? i_r[AW-1:0] : j_r[AW-1:0]),
    .rdata (rd0)
  );

  rslt_seg_ram #(
    .DEPTH (SEG_MAX),
    .AW    (AW)
  ) u_ram1 (
    .clk   (clk),
    .we    (bank_r && cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (bank_r ? cur_re : prev_re),
    .raddr (bank_r ? j_r[AW-1:0] : i_r[AW-1:0]),
    .rdata (rd1)
  );

  assign p = bank_r ? rd0 : rd1;
  assign c = bank_r ? rd1 : rd0;

  assign out_free  = !out_valid_r || out_ready;
  assign prev_line = (line_r == '0) ? LNW'(LINES_MAX - 1) : line_r - LNW'(1);

  always_comb begin
    state_nxt      = state_r;
    cur_count_nxt  = cur_count_r + CW'(seg_we);
    prev_count_nxt = prev_count_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    bank_nxt       = bank_r;
    fe_nxt         = fe_r;
    line_nxt       = line_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_ld         = 1'b0;
    out_ld_last    = 1'b0;
    unique case (state_r)
      rslt_pkg::ST_SCAN: begin
        if (in_acc && (in_line_end || in_frame_end)) begin
          fe_nxt    = in_frame_end;
          i_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = (prev_count_r == '0) ? rslt_pkg::ST_FLUSH : rslt_pkg::ST_PREV_RD;
        end
      end
      rslt_pkg::ST_PREV_RD: begin
        j_nxt     = cnt_r;
        state_nxt = rslt_pkg::ST_CUR_RD;
      end
      rslt_pkg::ST_CUR_RD: begin
        state_nxt = (j_r < cur_count_r) ? rslt_pkg::ST_CMP : rslt_pkg::ST_DECIDE;
      end
      rslt_pkg::ST_CMP: begin
        if (match) begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = rslt_pkg::ST_NEXT;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = rslt_pkg::ST_CUR_RD;
        end
      end
      rslt_pkg::ST_DECIDE: begin
        if (!emit_ok) begin
          state_nxt = rslt_pkg::ST_NEXT;
        end else if (!pend_v_r) begin
          pend_v_nxt = 1'b1;
          pend_nxt   = p;
          state_nxt  = rslt_pkg::ST_NEXT;
        end else if (out_free) begin
          out_ld    = 1'b1;
          pend_nxt  = p;
          state_nxt = rslt_pkg::ST_NEXT;
        end
      end
      rslt_pkg::ST_NEXT: begin
        i_nxt     = i_r + CW'(1);
        state_nxt = (i_nxt >= prev_count_r) ? rslt_pkg::ST_FLUSH : rslt_pkg::ST_PREV_RD;
      end
      rslt_pkg::ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = rslt_pkg::ST_SWAP;
        end else if (out_free) begin
          out_ld      = 1'b1;
          out_ld_last = 1'b1;
          pend_v_nxt  = 1'b0;
          state_nxt   = rslt_pkg::ST_SWAP;
        end
      end
      rslt_pkg::ST_SWAP: begin
        bank_nxt       = !bank_r;
        prev_count_nxt = fe_r ? '0 : cur_count_r;
        cur_count_nxt  = '0;
        if (fe_r) begin
          line_nxt = '0;
        end else begin
          line_nxt = (line_r == LNW'(LINES_MAX - 1)) ? '0 : line_r + LNW'(1);
        end
        state_nxt = rslt_pkg::ST_SCAN;
      end
      default: begin
        state_nxt = rslt_pkg::ST_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rslt_pkg::ST_SCAN;
      cur_count_r  <= '0;
      prev_count_r <= '0;
      i_r          <= '0;
      j_r          <= '0;
      cnt_r        <= '0;
      bank_r       <= 1'b0;
      fe_r         <= 1'b0;
      line_r       <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_count_r  <= cur_count_nxt;
      prev_count_r <= prev_count_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      cnt_r        <= cnt_nxt;
      bank_r       <= bank_nxt;
      fe_r         <= fe_nxt;
      line_r       <= line_nxt;
      pend_v_r     <= pend_v_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (out_ld) begin
      out_seg_r  <= pend_r;
      out_last_r <= out_ld_last;
      out_line_r <= 12'(prev_line);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_index = out_line_r;
  assign out_run_start  = out_seg_r.head[10:0];
  assign out_run_stop   = out_seg_r.tail[10:0];
  assign out_run_length = out_seg_r.len[11:0];
  assign out_thickness  = out_seg_r.thick;
  assign out_last       = out_last_r;

  a_cur_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cur_count_r <= CW'(SEG_MAX))
    else $error("current segment count beyond list depth");

  a_prev_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    prev_count_r <= CW'(SEG_MAX))
    else $error("previous segment count beyond list depth");

  a_no_pending_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rslt_pkg::ST_SCAN) |-> !pend_v_r)
    else $error("segment left pending after line end pass");

  a_cmp_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rslt_pkg::ST_CMP) |-> (j_r < cur_count_r))
    else $error("compare on a current segment beyond the list");

endmodule

### test/tb_top.sv
// Self-checking testbench for the run segment line tracker with a line-matching predictor.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [1:0] {K_PIX, K_CFG, K_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t                   kind;
    logic [7:0]                  pix;
    logic                        le;
    logic                        fe;
    logic [rslt_pkg::CFG_W-1:0]  idx;
    logic [rslt_pkg::DATA_W-1:0] data;
  } job_t;

  typedef struct packed {
    logic [11:0] line_index;
    logic [10:0] run_start;
    logic [10:0] run_stop;
    logic [11:0] run_length;
    logic [11:0] thickness;
    logic        last;
  } seg_word_t;

  typedef struct {
    int unsigned head;
    int unsigned tail;
    int unsigned len;
    int unsigned thick;
  } track_seg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rslt_pkg::CFG_W-1:0] cfg_index = '0;
  logic [rslt_pkg::DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_pixel = '0;
  logic in_line_end = 1'b0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [11:0] out_line_index;
  logic [10:0] out_run_start;
  logic [10:0] out_run_stop;
  logic [11:0] out_run_length;
  logic [11:0] out_thickness;
  logic out_last;

  run_segment_line_tracker DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .in_line_end(in_line_end), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_line_index(out_line_index), .out_run_start(out_run_start),
    .out_run_stop(out_run_stop), .out_run_length(out_run_length),
    .out_thickness(out_thickness), .out_last(out_last)
  );

  always #4 clk = ~clk;

  job_t      pend[$];
  seg_word_t seg_words_due[$];
  int        n_err = 0;
  int        n_sent = 0;
  bit        quiet = 0;
  logic      in_took = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        settle = 0;
  int        idle_cycles = 0;

  // Predictor state.
  track_seg_t cur_segs[64];
  track_seg_t prev_segs[64];
  int unsigned cur_n = 0, prev_n = 0, pos = 0, line_no = 0, head_at = 0;
  bit          open_run = 0;
  int unsigned p_dark = 128, p_min = 20, p_long = 50, p_short_th = 4, p_long_th = 2;

  // Generator view of the threshold.
  int gen_dark = 128;

  task automatic apply_reg(logic [rslt_pkg::CFG_W-1:0] idx, logic [rslt_pkg::DATA_W-1:0] d);
    case (idx)
      rslt_pkg::CFG_DARK_LEVEL:      p_dark = 32'(d[7:0]);
      rslt_pkg::CFG_MIN_RUN:         p_min = 32'(d);
      rslt_pkg::CFG_LONG_RUN:        p_long = 32'(d);
      rslt_pkg::CFG_SHORT_THICK_MIN: p_short_th = 32'(d);
      rslt_pkg::CFG_LONG_THICK_MIN:  p_long_th = 32'(d);
      default: ;
    endcase
  endtask

  task automatic close_line();
    int unsigned ctr, i, j, t;
    bit hit[64];
    bit ok, a, b;
    int n;
    int unsigned lp, lc;
    seg_word_t w;
    ctr = 0;
    n = 0;
    for (i = 0; i < prev_n; i++) begin
      hit[i] = 0;
      for (j = ctr; j < cur_n; j++) begin
        lp = prev_segs[i].len;
        lc = cur_segs[j].len;
        a = (prev_segs[i].tail > cur_segs[j].head) && (4 * lc < 5 * lp) && (5 * lp < 6 * lc);
        b = ((prev_segs[i].head == cur_segs[j].head) || (prev_segs[i].tail == cur_segs[j].tail))
            && (2 * lp > lc);
        if (a || b) begin
          t = cur_segs[j].thick + prev_segs[i].thick;
          cur_segs[j].thick = (t > 4095) ? 4095 : t;
          if (lp > lc) begin
            cur_segs[j].head = prev_segs[i].head;
            cur_segs[j].tail = prev_segs[i].tail;
            cur_segs[j].len = lp;
          end
          ctr++;
          hit[i] = 1;
          break;
        end
      end
    end
    for (i = 0; i < prev_n; i++) begin
      if (!hit[i]) begin
        if (prev_segs[i].len < p_long) ok = prev_segs[i].thick >= p_short_th;
        else ok = prev_segs[i].thick >= p_long_th;
        if (ok) begin
          w.line_index = 12'((line_no + 4095) % 4096);
          w.run_start = 11'(prev_segs[i].head);
          w.run_stop = 11'(prev_segs[i].tail);
          w.run_length = 12'(prev_segs[i].len);
          w.thickness = 12'(prev_segs[i].thick);
          w.last = 1'b0;
          seg_words_due.insert(seg_words_due.size(), w);
          n++;
        end
      end
    end
    if (n > 0) seg_words_due[seg_words_due.size() - 1].last = 1'b1;
    prev_segs = cur_segs;
    prev_n = cur_n;
    cur_n = 0;
    pos = 0;
    open_run = 0;
    head_at = 0;
    line_no = (line_no + 1) % 4096;
  endtask

  task automatic track_pixel(logic [7:0] pix, logic le, logic fe);
    int unsigned len;
    if (pos < 2048) begin
      if (pix < p_dark && !open_run) begin
        open_run = 1;
        head_at = pos;
      end
      if (pix > p_dark && open_run) begin
        len = pos - head_at;
        open_run = 0;
        if (len >= p_min && cur_n < 64) begin
          cur_segs[cur_n].head = head_at;
          cur_segs[cur_n].tail = pos - 1;
          cur_segs[cur_n].len = len;
          cur_segs[cur_n].thick = 1;
          cur_n++;
        end
      end
      pos++;
    end
    if (le || fe) close_line();
    if (fe) begin
      cur_n = 0;
      prev_n = 0;
      line_no = 0;
    end
  endtask

  // Sender, configuration writer and output ready driver.
  always @(negedge clk) begin : drive_proc
    logic v_n, we_n;
    v_n = in_valid;
    we_n = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_took) begin
        v_n = 1'b1;
      end else if (send_gap > 0) begin
        v_n = 1'b0;
        send_gap <= send_gap - 1;
      end else if (pend.size() == 0) begin
        v_n = 1'b0;
      end else begin
        case (pend[0].kind)
          K_PIX: begin
            v_n = 1'b1;
            in_pixel <= pend[0].pix;
            in_line_end <= pend[0].le;
            in_frame_end <= pend[0].fe;
            void'(pend.pop_front());
            if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 11);
          end
          K_CFG: begin
            v_n = 1'b0;
            we_n = 1'b1;
            cfg_index <= pend[0].idx;
            cfg_data <= pend[0].data;
            void'(pend.pop_front());
          end
          default: begin
            v_n = 1'b0;
            if (settle >= 4) begin
              settle <= 0;
              void'(pend.pop_front());
            end else if (seg_words_due.size() == 0 && in_ready && !out_valid) begin
              settle <= settle + 1;
            end else begin
              settle <= 0;
            end
          end
        endcase
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        recv_gap <= $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
    in_valid <= v_n;
    cfg_we <= we_n;
  end

  // Acceptance, prediction and result checking.
  always @(posedge clk) begin : check_proc
    seg_word_t w;
    if (rst_n) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) track_pixel(in_pixel, in_line_end, in_frame_end);
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (seg_words_due.size() == 0) begin
          $error("unexpected word: line_index %0d run_start %0d", out_line_index, out_run_start);
          n_err++;
        end else begin
          w = seg_words_due.pop_front();
          if (out_line_index !== w.line_index) begin
            $error("line_index expected %0d actual %0d", w.line_index, out_line_index);
            n_err++;
          end
          if (out_run_start !== w.run_start) begin
            $error("run_start expected %0d actual %0d", w.run_start, out_run_start);
            n_err++;
          end
          if (out_run_stop !== w.run_stop) begin
            $error("run_stop expected %0d actual %0d", w.run_stop, out_run_stop);
            n_err++;
          end
          if (out_run_length !== w.run_length) begin
            $error("run_length expected %0d actual %0d", w.run_length, out_run_length);
            n_err++;
          end
          if (out_thickness !== w.thickness) begin
            $error("thickness expected %0d actual %0d", w.thickness, out_thickness);
            n_err++;
          end
          if (out_last !== w.last) begin
            $error("last expected %0d actual %0d", w.last, out_last);
            n_err++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 100000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_pix(logic [7:0] p, logic le, logic fe);
    job_t j;
    j.kind = K_PIX;
    j.pix = p;
    j.le = le;
    j.fe = fe;
    j.idx = '0;
    j.data = '0;
    pend.insert(pend.size(), j);
    n_sent++;
  endtask

  task automatic push_cfg(logic [rslt_pkg::CFG_W-1:0] idx, int d);
    job_t j;
    j.kind = K_CFG;
    j.pix = '0;
    j.le = 0;
    j.fe = 0;
    j.idx = idx;
    j.data = rslt_pkg::DATA_W'(d);
    if (idx == rslt_pkg::CFG_DARK_LEVEL) gen_dark = d;
    pend.insert(pend.size(), j);
  endtask

  task automatic settle_down();
    job_t j;
    j.kind = K_DRAIN;
    j.pix = '0;
    j.le = 0;
    j.fe = 0;
    j.idx = '0;
    j.data = '0;
    pend.insert(pend.size(), j);
    while (pend.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] dark_px();
    return (gen_dark > 0) ? 8'($urandom_range(0, gen_dark - 1)) : 8'd0;
  endfunction

  function automatic logic [7:0] bright_px();
    return (gen_dark < 255) ? 8'($urandom_range(gen_dark + 1, 255)) : 8'd255;
  endfunction

  task automatic set_all(int dk, int mn, int lg, int sh, int lt);
    push_cfg(rslt_pkg::CFG_DARK_LEVEL, dk);
    push_cfg(rslt_pkg::CFG_MIN_RUN, mn);
    push_cfg(rslt_pkg::CFG_LONG_RUN, lg);
    push_cfg(rslt_pkg::CFG_SHORT_THICK_MIN, sh);
    push_cfg(rslt_pkg::CFG_LONG_THICK_MIN, lt);
  endtask

  task automatic gen_frame(int n_lines, int width);
    int nseg, s, ln, x, stop_at, h, e;
    int bh[3], bl[3];
    bit dk[];
    nseg = $urandom_range(1, 3);
    for (s = 0; s < nseg; s++) begin
      bl[s] = $urandom_range(1, width / 3);
      bh[s] = $urandom_range(0, width - bl[s] - 1);
    end
    for (ln = 0; ln < n_lines; ln++) begin
      dk = new[width];
      for (x = 0; x < width; x++) dk[x] = 0;
      for (s = 0; s < nseg; s++) begin
        if ($urandom_range(0, 9) != 0) begin
          h = bh[s] + $urandom_range(0, 2) - 1;
          e = bh[s] + bl[s] - 1 + $urandom_range(0, 2) - 1;
          for (x = (h < 0 ? 0 : h); x <= e && x < width; x++) dk[x] = 1;
        end
      end
      stop_at = ($urandom_range(0, 14) == 0) ? $urandom_range(1, width) : width;
      for (x = 0; x < stop_at; x++) begin
        logic [7:0] p;
        if ($urandom_range(0, 7) == 0 && ln % 5 == 3) p = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 19) == 0) p = 8'(gen_dark);
        else p = dk[x] ? dark_px() : bright_px();
        push_pix(p, x == stop_at - 1,
                 (x == stop_at - 1) && (ln == n_lines - 1) && ($urandom_range(0, 2) != 0));
      end
    end
  endtask

  initial begin : stim_proc
    int i, k, n_phase;
    for (i = 0; i < 64; i++) begin
      cur_segs[i] = '{0, 0, 0, 0};
      prev_segs[i] = '{0, 0, 0, 0};
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: defaults, then extreme thresholds.
    for (k = 0; k < 3; k++) begin
      push_pix(8'd255, 0, 0);
      for (i = 0; i < 3; i++) push_pix(8'd0, 0, 0);
      push_pix(8'd128, 0, 0);
      push_pix(8'd200, 1, 0);
    end
    push_pix(8'd10, 0, 0);
    push_pix(8'd10, 0, 1);
    settle_down();
    set_all(255, 1, 1, 1, 1);
    push_pix(8'd254, 0, 0);
    push_pix(8'd255, 0, 0);
    push_pix(8'd0, 1, 0);
    push_pix(8'd255, 1, 1);
    settle_down();
    set_all(0, 0, 0, 0, 0);
    push_pix(8'd0, 0, 0);
    push_pix(8'd5, 1, 0);
    push_pix(8'd0, 1, 1);
    settle_down();
    set_all(128, 2048, 2048, 4095, 4095);
    push_pix(8'd3, 0, 0);
    push_pix(8'd250, 1, 1);
    settle_down();

    // An overfull segment list, then a line end that emits the whole list.
    set_all(128, 1, 50, 1, 1);
    for (i = 0; i < 66; i++) begin
      push_pix(8'd0, 0, 0);
      push_pix(8'd200, i == 65, 0);
    end
    push_pix(8'd200, 1, 1);
    settle_down();

    n_phase = 0;
    while (n_sent < 460 && n_phase < 60) begin
      if (n_sent > 400) quiet = 1;
      set_all($urandom_range(16, 240), $urandom_range(1, 4), $urandom_range(2, 10),
              $urandom_range(1, 4), $urandom_range(1, 3));
      gen_frame($urandom_range(3, 6), $urandom_range(8, 20));
      settle_down();
      n_phase++;
    end

    repeat (100) @(posedge clk);
    if (n_err == 0 && seg_words_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
